// ===== rtl/core/assert_macros.svh =====
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every clock edge outside reset
`define RPN_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("rpn check failed");

// antecedent in one cycle implies consequent in the next
`define RPN_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("rpn check failed");

`endif

// ===== rtl/core/rpn_pkg.sv =====
`default_nettype none
package rpn_pkg;

   localparam int STACK_DEPTH = 16;
   localparam int DATA_W      = 32;
   localparam int COUNT_W     = $clog2(STACK_DEPTH + 1);
   localparam int ADDR_W      = (STACK_DEPTH > 2) ? $clog2(STACK_DEPTH) : 1;

   typedef enum logic [1:0] {
      TOKEN_OPERAND = 2'd0,
      TOKEN_ADD     = 2'd1,
      TOKEN_SUB     = 2'd2,
      TOKEN_MUL     = 2'd3
   } token_kind_type;

   typedef enum logic [1:0] {
      STATUS_OK        = 2'd0,
      STATUS_UNDERFLOW = 2'd1,
      STATUS_OVERFLOW  = 2'd2,
      STATUS_EMPTY     = 2'd3
   } status_type;

   typedef logic [DATA_W-1:0] data_type;

   typedef struct packed {
      data_type   result_value;
      status_type status;
   } rsp_item_type;

endpackage
`default_nettype wire

// ===== rtl/core/rpn_intf.sv =====
`default_nettype none
interface rpn_req_if;
   import rpn_pkg::*;

   logic                     valid;
   logic                     ready;
   logic [1:0]               req_type;
   logic signed [DATA_W-1:0] operand_value;
   logic                     last_token;

   modport source (output valid, output req_type, output operand_value,
                   output last_token, input ready);
   modport sink   (input valid, input req_type, input operand_value,
                   input last_token, output ready);
endinterface

interface rpn_rsp_if;
   import rpn_pkg::*;

   logic                     valid;
   logic                     ready;
   logic signed [DATA_W-1:0] result_value;
   logic [1:0]               status;

   modport source (output valid, output result_value, output status, input ready);
   modport sink   (input valid, input result_value, input status, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/rpn_stack_evaluator_core.sv =====
// the result of a last-token request enters the output buffer on acceptance
// throughput: one request per cycle unless the output buffer is full;
// top two stack entries live in registers, deeper entries in a one-port-write,
// one-port-read memory with registered read; a two-entry output buffer keeps
// requests flowing while a result waits; reset (synchronous): clears stack
// count, error latch and output valids; stack memory is never cleared
`default_nettype none
module rpn_stack_evaluator_core (
   input  wire logic   clock,
   input  wire logic   reset,
   rpn_req_if.sink     req_bus,
   rpn_rsp_if.source   rsp_bus
);
   import rpn_pkg::*;

   data_type               stack_mem [STACK_DEPTH];

   logic [COUNT_W-1:0]     cnt_ff, cnt_in;
   data_type               tos_ff, tos_in;
   data_type               nos_ff, nos_in;
   status_type             err_ff, err_in;

   logic                   mem_we;
   logic [ADDR_W-1:0]      mem_waddr, mem_raddr;
   logic [COUNT_W-1:0]     wr_idx, rd_idx;
   data_type               rd_data_ff;
   logic                   fwd_ff, fwd_in;
   data_type               fwd_data_ff;
   data_type               third;

   rsp_item_type           out0_ff, out0_in, out1_ff, out1_in, new_item;
   logic                   v0_ff, v0_in, v1_ff, v1_in;
   logic                   push, pop;

   logic                   accept;
   token_kind_type         kind;
   data_type               alu;
   status_type             tok_err, err_next;

   assign accept  = req_bus.valid && req_bus.ready;
   assign kind    = token_kind_type'(req_bus.req_type);
   assign third   = fwd_ff ? fwd_data_ff : rd_data_ff;

   assign wr_idx    = cnt_ff - COUNT_W'(2);
   assign mem_waddr = wr_idx[ADDR_W-1:0];
   assign rd_idx    = cnt_in - COUNT_W'(3);
   assign mem_raddr = rd_idx[ADDR_W-1:0];
   assign fwd_in    = mem_we && (mem_waddr == mem_raddr);

   always_comb begin
      unique case (kind)
         TOKEN_ADD:     alu = nos_ff + tos_ff;
         TOKEN_SUB:     alu = nos_ff - tos_ff;
         TOKEN_MUL:     alu = nos_ff * tos_ff;
         TOKEN_OPERAND: alu = '0;
      endcase
   end

   // stack update
   always_comb begin
      cnt_in   = cnt_ff;
      tos_in   = tos_ff;
      nos_in   = nos_ff;
      err_in   = err_ff;
      mem_we   = 1'b0;
      tok_err  = STATUS_OK;
      err_next = err_ff;
      push     = 1'b0;
      new_item = '{result_value: '0, status: STATUS_OK};
      if (accept) begin
         if (kind == TOKEN_OPERAND) begin
            if (cnt_ff == COUNT_W'(STACK_DEPTH)) begin
               tok_err = STATUS_OVERFLOW;
            end else begin
               tos_in = data_type'(req_bus.operand_value);
               nos_in = tos_ff;
               mem_we = (cnt_ff >= COUNT_W'(2));
               cnt_in = cnt_ff + COUNT_W'(1);
            end
         end else begin
            if (cnt_ff < COUNT_W'(2)) begin
               tok_err = STATUS_UNDERFLOW;
            end else begin
               tos_in = alu;
               nos_in = third;
               cnt_in = cnt_ff - COUNT_W'(1);
            end
         end
         err_next = (err_ff != STATUS_OK) ? err_ff : tok_err;
         if (req_bus.last_token) begin
            push = 1'b1;
            if (cnt_in != '0) begin
               new_item = '{result_value: tos_in, status: err_next};
            end else begin
               new_item = '{result_value: '0,
                            status: (err_next == STATUS_OK) ? STATUS_EMPTY : err_next};
            end
            cnt_in = '0;
            err_in = STATUS_OK;
         end else begin
            err_in = err_next;
         end
      end
   end

   // output buffer
   assign pop = v0_ff && rsp_bus.ready;

   always_comb begin
      out0_in = out0_ff;
      out1_in = out1_ff;
      v0_in   = v0_ff;
      v1_in   = v1_ff;
      if (!v0_ff || pop) begin
         if (v1_ff) begin
            out0_in = out1_ff;
            v0_in   = 1'b1;
            v1_in   = push;
            out1_in = new_item;
         end else begin
            v0_in   = push;
            out0_in = new_item;
            v1_in   = 1'b0;
         end
      end else if (push) begin
         out1_in = new_item;
         v1_in   = 1'b1;
      end
   end

   assign req_bus.ready        = !v1_ff;
   assign rsp_bus.valid        = v0_ff;
   assign rsp_bus.result_value = out0_ff.result_value;
   assign rsp_bus.status       = out0_ff.status;

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
         err_ff <= STATUS_OK;
         v0_ff  <= 1'b0;
         v1_ff  <= 1'b0;
      end else begin
         cnt_ff <= cnt_in;
         err_ff <= err_in;
         v0_ff  <= v0_in;
         v1_ff  <= v1_in;
      end
   end

   always_ff @(posedge clock) begin
      tos_ff      <= tos_in;
      nos_ff      <= nos_in;
      out0_ff     <= out0_in;
      out1_ff     <= out1_in;
      fwd_ff      <= fwd_in;
      fwd_data_ff <= nos_ff;
   end

   // stack memory, entries below the top two
   always_ff @(posedge clock) begin
      if (mem_we) begin
         stack_mem[mem_waddr] <= nos_ff;
      end
      rd_data_ff <= stack_mem[mem_raddr];
   end

endmodule
`default_nettype wire

// ===== rtl/core/rpn_checker.sv =====
`default_nettype none
`include "assert_macros.svh"
module rpn_checker (
   input wire logic                 clock,
   input wire logic                 reset,
   input wire logic                 req_valid,
   input wire logic                 req_ready,
   input wire logic                 req_last,
   input wire logic                 rsp_valid,
   input wire logic                 rsp_ready,
   input wire logic [rpn_pkg::DATA_W-1:0] rsp_result,
   input wire logic [1:0]           rsp_status
);
   import rpn_pkg::*;

   logic req_last_acc;
   logic rsp_stall;

   assign req_last_acc = req_valid && req_ready && req_last;
   assign rsp_stall    = rsp_valid && !rsp_ready;

   // stalled response holds
   `RPN_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_stall,
                    rsp_valid && $stable(rsp_result) && $stable(rsp_status))
   // a fresh response comes only from a last-token request
   `RPN_ASSERT(a_rsp_cause, clock, reset, $rose(rsp_valid) |-> $past(req_last_acc))
   // empty-at-end reports zero
   `RPN_ASSERT(a_empty_zero, clock, reset,
               (rsp_valid && rsp_status == STATUS_EMPTY) |-> (rsp_result == '0))
   // backpressure only after the response side stalled
   `RPN_ASSERT(a_ready_drop, clock, reset, $fell(req_ready) |-> $past(rsp_stall))

endmodule

bind rpn_stack_evaluator_core rpn_checker u_rpn_checker (
   .clock      (clock),
   .reset      (reset),
   .req_valid  (req_bus.valid),
   .req_ready  (req_bus.ready),
   .req_last   (req_bus.last_token),
   .rsp_valid  (rsp_bus.valid),
   .rsp_ready  (rsp_bus.ready),
   .rsp_result (rsp_bus.result_value),
   .rsp_status (rsp_bus.status)
);
`default_nettype wire

// ===== sim/tb_rpn_stack_evaluator_core.sv =====
`default_nettype none
module tb_rpn_stack_evaluator_core;
   import rpn_pkg::*;

   localparam int RANDOM_ITEMS   = 1900;
   localparam int WATCHDOG_LIMIT = 5000;
   localparam int TAIL_CYCLES    = 8;
   localparam int DRAIN_EVERY    = 40;

   typedef struct {
      token_kind_type kind;
      data_type       value;
      logic           last;
      bit             typed;
      data_type       want_value;
      status_type     want_status;
   } req_token_type;

   logic clock;
   logic reset;

   rpn_req_if req_bus ();
   rpn_rsp_if rsp_bus ();

   rpn_stack_evaluator_core uut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   // predictor state
   data_type   stack_copy [STACK_DEPTH];
   int         stack_fill = 0;
   status_type sticky_status = STATUS_OK;

   req_token_type token_backlog [$];
   req_token_type pending_tokens [$];
   rsp_item_type  expected_results [$];

   int          error_count = 0;
   int          burst_left = 0;
   int unsigned idle_cycles = 0;
   int          stall_mode = 0;
   int          stall_cycles = 0;

   initial clock = 1'b0;
   always #5 clock = ~clock;

   function automatic req_token_type make_token(token_kind_type kind, data_type value,
                                                logic last, bit typed = 1'b0,
                                                data_type want_value = '0,
                                                status_type want_status = STATUS_OK);
      req_token_type tok;
      tok.kind        = kind;
      tok.value       = value;
      tok.last        = last;
      tok.typed       = typed;
      tok.want_value  = want_value;
      tok.want_status = want_status;
      return tok;
   endfunction

   function automatic data_type pick_operand();
      case ($urandom_range(0, 7))
         0: return 32'h8000_0000;
         1: return 32'h7fff_ffff;
         2: return 32'h0000_0000;
         3: return 32'hffff_ffff;
         4, 5: return data_type'($urandom_range(0, 15));
         default: return $urandom;
      endcase
   endfunction

   task automatic apply_token(input req_token_type tok, output bit produced,
                              output rsp_item_type res);
      data_type lhs;
      data_type rhs;
      produced = 1'b0;
      res      = '0;
      if (tok.kind == TOKEN_OPERAND) begin
         if (stack_fill >= STACK_DEPTH) begin
            if (sticky_status == STATUS_OK) sticky_status = STATUS_OVERFLOW;
         end else begin
            stack_copy[stack_fill] = tok.value;
            stack_fill++;
         end
      end else if (stack_fill < 2) begin
         if (sticky_status == STATUS_OK) sticky_status = STATUS_UNDERFLOW;
      end else begin
         rhs = stack_copy[stack_fill-1];
         lhs = stack_copy[stack_fill-2];
         case (tok.kind)
            TOKEN_ADD: stack_copy[stack_fill-2] = lhs + rhs;
            TOKEN_SUB: stack_copy[stack_fill-2] = lhs - rhs;
            default:   stack_copy[stack_fill-2] = lhs * rhs;
         endcase
         stack_fill--;
      end
      if (tok.last) begin
         produced   = 1'b1;
         res.status = sticky_status;
         if (stack_fill > 0) res.result_value = stack_copy[stack_fill-1];
         else if (sticky_status == STATUS_OK) res.status = STATUS_EMPTY;
         stack_fill    = 0;
         sticky_status = STATUS_OK;
      end
   endtask

   task automatic build_expression();
      int mode;
      int operands;
      int depth;
      int extra;
      int i;
      mode = $urandom_range(0, 9);
      if (mode < 8) begin
         // well-formed expression
         operands = ($urandom_range(0, 9) == 0) ? $urandom_range(9, STACK_DEPTH)
                                                : $urandom_range(1, 6);
         depth = 0;
         while (operands > 0 || depth > 1) begin
            if (operands > 0 && (depth < 2 || $urandom_range(0, 1) == 1)) begin
               token_backlog.push_back(make_token(TOKEN_OPERAND, pick_operand(), 1'b0));
               operands--;
               depth++;
            end else begin
               token_backlog.push_back(make_token(token_kind_type'($urandom_range(1, 3)),
                                                  $urandom, 1'b0));
               depth--;
            end
         end
      end else if (mode == 8) begin
         // push past the top of the stack
         extra = STACK_DEPTH + $urandom_range(1, 3);
         for (i = 0; i < extra; i++)
            token_backlog.push_back(make_token(TOKEN_OPERAND, pick_operand(), 1'b0));
         extra = $urandom_range(0, 3);
         for (i = 0; i < extra; i++)
            token_backlog.push_back(make_token(token_kind_type'($urandom_range(1, 3)),
                                               $urandom, 1'b0));
      end else begin
         // noise
         extra = $urandom_range(1, 8);
         for (i = 0; i < extra; i++)
            token_backlog.push_back(make_token(token_kind_type'($urandom_range(0, 3)),
                                               $urandom, ($urandom_range(0, 3) == 0)));
      end
      token_backlog[token_backlog.size()-1].last = 1'b1;
   endtask

   task automatic send_token(input req_token_type tok);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         if (gap > 0) begin
            req_bus.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_bus.valid         <= 1'b1;
      req_bus.req_type      <= tok.kind;
      req_bus.operand_value <= tok.value;
      req_bus.last_token    <= tok.last;
      pending_tokens.push_back(tok);
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
   endtask

   task automatic drain_results();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (expected_results.size() != 0) @(posedge clock);
   endtask

   task automatic report_mismatch(input string what, input data_type got, input data_type want);
      $display("mismatch %s: got %h want %h at %0t", what, got, want, $time);
      error_count++;
   endtask

   // receiver stall pattern
   always @(posedge clock) begin
      if (stall_cycles == 0) begin
         stall_mode   <= $urandom_range(0, 3);
         stall_cycles <= $urandom_range(16, 96);
      end else begin
         stall_cycles <= stall_cycles - 1;
      end
      case (stall_mode)
         0: rsp_bus.ready <= 1'b1;
         1: rsp_bus.ready <= $urandom_range(0, 1);
         2: rsp_bus.ready <= (stall_cycles % 4 != 0);
         default: rsp_bus.ready <= ($urandom_range(0, 3) == 0);
      endcase
   end

   always @(posedge clock) begin : monitor
      req_token_type tok;
      rsp_item_type  res;
      rsp_item_type  want;
      bit            produced;
      if (!reset) begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (expected_results.size() == 0) begin
               report_mismatch("unexpected result", rsp_bus.result_value, '0);
            end else begin
               want = expected_results.pop_front();
               if (rsp_bus.result_value !== want.result_value)
                  report_mismatch("result_value", rsp_bus.result_value, want.result_value);
               if (rsp_bus.status !== want.status)
                  report_mismatch("status", data_type'(rsp_bus.status), data_type'(want.status));
            end
         end
         if (req_bus.valid && req_bus.ready) begin
            tok = pending_tokens.pop_front();
            apply_token(tok, produced, res);
            if (produced) begin
               if (tok.typed) begin
                  res.result_value = tok.want_value;
                  res.status       = tok.want_status;
               end
               expected_results.push_back(res);
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   initial begin
      int i;
      int directed_count;
      int random_sent;
      int expression_count;
      rsp_item_type want;

      reset                 <= 1'b1;
      req_bus.valid         <= 1'b0;
      req_bus.req_type      <= TOKEN_OPERAND;
      req_bus.operand_value <= '0;
      req_bus.last_token    <= 1'b0;

      // directed table
      token_backlog.push_back(make_token(TOKEN_ADD, 32'h1234_5678, 1'b1,
                                         1'b1, 32'h0, STATUS_UNDERFLOW));
      token_backlog.push_back(make_token(TOKEN_OPERAND, 32'hffff_ffff, 1'b0));
      token_backlog.push_back(make_token(TOKEN_OPERAND, 32'h0000_0001, 1'b0));
      token_backlog.push_back(make_token(TOKEN_ADD, 32'h0, 1'b1, 1'b1, 32'h0, STATUS_OK));
      token_backlog.push_back(make_token(TOKEN_OPERAND, 32'h8000_0000, 1'b0));
      token_backlog.push_back(make_token(TOKEN_OPERAND, 32'h0000_0001, 1'b0));
      token_backlog.push_back(make_token(TOKEN_SUB, 32'hffff_ffff, 1'b0));
      token_backlog.push_back(make_token(TOKEN_OPERAND, 32'h0000_0002, 1'b0));
      token_backlog.push_back(make_token(TOKEN_MUL, 32'h0, 1'b1));
      for (i = 0; i < STACK_DEPTH; i++)
         token_backlog.push_back(make_token(TOKEN_OPERAND,
                                            (i == STACK_DEPTH - 1) ? 32'h7fff_ffff : i, 1'b0));
      token_backlog.push_back(make_token(TOKEN_OPERAND, 32'hdead_beef, 1'b1,
                                         1'b1, 32'h7fff_ffff, STATUS_OVERFLOW));
      directed_count = token_backlog.size();

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      for (i = 0; i < directed_count; i++)
         send_token(token_backlog.pop_front());
      drain_results();

      random_sent      = 0;
      expression_count = 0;
      while (random_sent < RANDOM_ITEMS || token_backlog.size() != 0) begin
         if (token_backlog.size() == 0) begin
            expression_count++;
            if (expression_count % DRAIN_EVERY == 0) drain_results();
            build_expression();
         end
         send_token(token_backlog.pop_front());
         random_sent++;
      end

      drain_results();
      repeat (TAIL_CYCLES) @(posedge clock);
      while (expected_results.size() != 0) begin
         want = expected_results.pop_front();
         report_mismatch("missing result", '0, want.result_value);
      end
      if (error_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end
endmodule
`default_nettype wire

// ===== files.f =====
+incdir+rtl/core
rtl/core/rpn_pkg.sv
rtl/core/rpn_intf.sv
rtl/core/rpn_stack_evaluator_core.sv
rtl/core/rpn_checker.sv
sim/tb_rpn_stack_evaluator_core.sv
